@@ hw/rtl/omrs_pkg.sv @@
// shared types and constants of the ordered multiset rank/select block
package omrs_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_RANK   = 3'd2;
    localparam logic [2:0] OP_KTH    = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic [1:0]         status;
    } out_item_t;

    // binary search request and response
    typedef struct packed {
        logic               start;
        logic               inclusive;
        logic signed [31:0] key;
    } srch_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] pos;
    } srch_rsp_t;

endpackage

@@ hw/rtl/ordered_multiset_rank_select_top.sv @@
// top level of the ordered multiset rank/select block
//
//  channel | dir | ports                      | payload
//  s_      | in  | s_valid, s_ready, s_item   | opcode, operand
//  m_      | out | m_valid, m_ready, m_item   | answer, status
//
// one item at a time over a single store port with registered read
// accept, then binary search: each probe passes SRCH_CMP, SRCH_RD and SRCH_WT
// then a dispatch state and a store read (RD_WT, RD_DONE) where the opcode needs one
// insert/delete shift sweep: each moved entry passes SH_RD, SH_WT and SH_WR
// reset clears only the state and the count; the store holds no reset state
// the result waits in its register until m_ready; no new item meanwhile
module ordered_multiset_rank_select_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  omrs_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output omrs_pkg::out_item_t m_item
);
    logic                       mem_we;
    logic [omrs_pkg::IDX_W-1:0] mem_addr;
    logic signed [31:0]         mem_wdata;
    logic signed [31:0]         mem_rdata;

    // sequencer owning the store port
    omrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // sorted value store
    omrs_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );
endmodule

@@ hw/rtl/omrs_mem.sv @@
// single-port value store with registered read
module omrs_mem (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [omrs_pkg::IDX_W-1:0] addr,
    input  logic signed [31:0]        wdata,
    output logic signed [31:0]        rdata
);
    logic signed [31:0] mem [omrs_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/omrs_ctrl.sv @@
// sequencer: binary search, shift sweep and result formation over one store port
module omrs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  omrs_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output omrs_pkg::out_item_t         m_item,
    output logic                        mem_we,
    output logic [omrs_pkg::IDX_W-1:0]  mem_addr,
    output logic signed [31:0]          mem_wdata,
    input  logic signed [31:0]          mem_rdata
);
    localparam int CW = omrs_pkg::CNT_W;
    localparam int IW = omrs_pkg::IDX_W;

    typedef enum logic [3:0] {
        IDLE, SRCH_RD, SRCH_WT, SRCH_CMP, DISPATCH, RD_WT, RD_DONE,
        SH_RD, SH_WT, SH_WR, INS_WR, OUT
    } state_t;

    state_t             state_reg;
    omrs_pkg::in_item_t item_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      lo_reg, hi_reg;
    logic [CW-1:0]      ptr_reg;
    logic               incl_reg;
    logic signed [31:0] ans_reg;
    logic [1:0]         st_reg;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      src_addr;
    logic               go_left;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_left = incl_reg ? (mem_rdata <= item_reg.operand)
                              : (mem_rdata < item_reg.operand);

    // sweep source: one below the slot for insert, one above for delete
    assign src_addr = (item_reg.opcode == omrs_pkg::OP_INSERT) ? ptr_reg - 1'b1
                                                              : ptr_reg + 1'b1;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == OUT);
    assign m_item.answer = ans_reg;
    assign m_item.status = st_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = item_reg.operand;
        mem_addr  = ptr_reg[IW-1:0];
        case (state_reg)
            SRCH_RD: mem_addr = mid[IW-1:0];
            SH_RD:   mem_addr = src_addr[IW-1:0];
            SH_WR:   begin
                mem_we    = 1'b1;
                mem_wdata = ans_reg;
            end
            INS_WR:  mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                IDLE: if (s_valid) begin
                    item_reg <= s_item;
                    lo_reg   <= '0;
                    hi_reg   <= count_reg;
                    incl_reg <= (s_item.opcode == omrs_pkg::OP_INSERT) ||
                                (s_item.opcode == omrs_pkg::OP_SUCC);
                    ans_reg  <= '0;
                    st_reg   <= omrs_pkg::ST_OK;
                    state_reg <= SRCH_CMP;
                end
                SRCH_CMP: state_reg <= (lo_reg < hi_reg) ? SRCH_RD : DISPATCH;
                SRCH_RD: state_reg <= SRCH_WT;
                SRCH_WT: begin
                    if (go_left) lo_reg <= mid + 1'b1;
                    else         hi_reg <= mid;
                    state_reg <= SRCH_CMP;
                end
                DISPATCH: begin
                    case (item_reg.opcode)
                        omrs_pkg::OP_INSERT: begin
                            if (count_reg >= CW'(omrs_pkg::CAPACITY)) begin
                                st_reg    <= omrs_pkg::ST_FULL;
                                state_reg <= OUT;
                            end else begin
                                ptr_reg   <= count_reg;
                                state_reg <= (count_reg == lo_reg) ? INS_WR : SH_RD;
                            end
                        end
                        omrs_pkg::OP_DELETE: begin
                            if (lo_reg >= count_reg) begin
                                st_reg    <= omrs_pkg::ST_MISS;
                                state_reg <= OUT;
                            end else begin
                                ptr_reg   <= lo_reg;
                                state_reg <= RD_WT;
                            end
                        end
                        omrs_pkg::OP_RANK: begin
                            ans_reg   <= 32'(lo_reg) + 32'sd1;
                            state_reg <= OUT;
                        end
                        omrs_pkg::OP_KTH: begin
                            if (item_reg.operand < 1 ||
                                item_reg.operand > $signed({1'b0, 32'(count_reg)})) begin
                                st_reg    <= omrs_pkg::ST_MISS;
                                state_reg <= OUT;
                            end else begin
                                ptr_reg   <= CW'(item_reg.operand - 1);
                                state_reg <= RD_WT;
                            end
                        end
                        omrs_pkg::OP_PRED: begin
                            if (lo_reg == '0) begin
                                st_reg    <= omrs_pkg::ST_MISS;
                                state_reg <= OUT;
                            end else begin
                                ptr_reg   <= lo_reg - 1'b1;
                                state_reg <= RD_WT;
                            end
                        end
                        omrs_pkg::OP_SUCC: begin
                            if (lo_reg >= count_reg) begin
                                st_reg    <= omrs_pkg::ST_MISS;
                                state_reg <= OUT;
                            end else begin
                                ptr_reg   <= lo_reg;
                                state_reg <= RD_WT;
                            end
                        end
                        default: begin
                            st_reg    <= omrs_pkg::ST_MISS;
                            state_reg <= OUT;
                        end
                    endcase
                end
                RD_WT: state_reg <= RD_DONE;
                RD_DONE: begin
                    if (item_reg.opcode == omrs_pkg::OP_DELETE) begin
                        if (mem_rdata != item_reg.operand) begin
                            st_reg    <= omrs_pkg::ST_MISS;
                            state_reg <= OUT;
                        end else begin
                            count_reg <= count_reg - 1'b1;
                            // close the gap: move entries ptr+1.. down one
                            if (ptr_reg + 1'b1 >= count_reg) begin
                                state_reg <= OUT;
                            end else begin
                                state_reg <= SH_RD;
                            end
                        end
                    end else begin
                        ans_reg   <= mem_rdata;
                        state_reg <= OUT;
                    end
                end
                // ptr is the destination slot, src_addr the entry moved into it
                SH_RD: state_reg <= SH_WT;
                SH_WT: begin
                    ans_reg   <= mem_rdata;
                    state_reg <= SH_WR;
                end
                SH_WR: begin
                    if (item_reg.opcode == omrs_pkg::OP_INSERT) begin
                        if (ptr_reg - 1'b1 == lo_reg) begin
                            ptr_reg   <= lo_reg;
                            state_reg <= INS_WR;
                        end else begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= SH_RD;
                        end
                    end else begin
                        // count already holds the reduced size here
                        if (ptr_reg + 1'b1 >= count_reg) begin
                            ans_reg   <= '0;
                            state_reg <= OUT;
                        end else begin
                            ptr_reg   <= ptr_reg + 1'b1;
                            state_reg <= SH_RD;
                        end
                    end
                end
                INS_WR: begin
                    count_reg <= count_reg + 1'b1;
                    ans_reg   <= '0;
                    state_reg <= OUT;
                end
                OUT: if (m_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

@@ tb/ordered_multiset_rank_select_top_test.sv @@
// testbench of the ordered multiset rank/select block
`timescale 1ns / 1ps

module ordered_multiset_rank_select_top_test;

    // ordered store mirror: predicts the result of each accepted item
    class multiset_scoreboard;
        int                   vals[$];
        omrs_pkg::out_item_t  pending[$];
        int                   errors;
        int                   checked;
        int                   full_hits;
        int                   peak;

        // count of stored values below v, or at most v when incl
        function int count_le(logic signed [31:0] v, bit incl);
            int n;
            n = 0;
            foreach (vals[i]) begin
                if (incl ? (vals[i] <= v) : (vals[i] < v)) n++;
            end
            return n;
        endfunction

        function void note_item(omrs_pkg::in_item_t it);
            omrs_pkg::out_item_t r;
            int p;
            r.answer = '0;
            r.status = omrs_pkg::ST_OK;
            case (it.opcode)
                omrs_pkg::OP_INSERT: begin
                    if (vals.size() >= omrs_pkg::CAPACITY) begin
                        r.status = omrs_pkg::ST_FULL;
                        full_hits++;
                    end else begin
                        p = count_le(it.operand, 1'b1);
                        vals.insert(p, it.operand);
                        if (vals.size() > peak) peak = vals.size();
                    end
                end
                omrs_pkg::OP_DELETE: begin
                    p = count_le(it.operand, 1'b0);
                    if (p >= vals.size() || vals[p] != it.operand)
                        r.status = omrs_pkg::ST_MISS;
                    else vals.delete(p);
                end
                omrs_pkg::OP_RANK: r.answer = count_le(it.operand, 1'b0) + 1;
                omrs_pkg::OP_KTH: begin
                    if (it.operand < 1 || it.operand > vals.size())
                        r.status = omrs_pkg::ST_MISS;
                    else r.answer = vals[it.operand - 1];
                end
                omrs_pkg::OP_PRED: begin
                    p = count_le(it.operand, 1'b0);
                    if (p == 0) r.status = omrs_pkg::ST_MISS;
                    else r.answer = vals[p - 1];
                end
                omrs_pkg::OP_SUCC: begin
                    p = count_le(it.operand, 1'b1);
                    if (p >= vals.size()) r.status = omrs_pkg::ST_MISS;
                    else r.answer = vals[p];
                end
                default: r.status = omrs_pkg::ST_MISS;
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                     checked);
            errors++;
        endtask

        task check_result(omrs_pkg::out_item_t got);
            omrs_pkg::out_item_t want;
            if (pending.size() == 0) begin
                report("unexpected result", got.status, -1);
                return;
            end
            want = pending.pop_front();
            if (got.answer !== want.answer) report("answer", got.answer, want.answer);
            if (got.status !== want.status) report("status", got.status, want.status);
            checked++;
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    omrs_pkg::in_item_t   s_item;
    logic                 m_valid;
    logic                 m_ready;
    omrs_pkg::out_item_t  m_item;

    multiset_scoreboard sb;
    int  sent;
    bit  hold_off;       // receiver long stall requested
    bit  random_stall;   // receiver random stall pattern enabled
    logic signed [31:0] pool[16];

    ordered_multiset_rank_select_top u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // one item: drive at the edge, hold until accepted
    task send_item(logic [2:0] op, logic signed [31:0] val);
        omrs_pkg::in_item_t it;
        it.opcode  = op;
        it.operand = val;
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
        sent++;
    endtask

    task idle_cycles(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // operand drawn mostly from a small pool so that lookups hit
    function logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return pool[$urandom_range(0, 15)] + $signed($urandom_range(0, 2)) - 1;
        else if (r == 7) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        else return $urandom;
    endfunction

    function logic [2:0] pick_op(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 20)) return omrs_pkg::OP_INSERT;
        if (r < (grow ? 62 : 45)) return omrs_pkg::OP_DELETE;
        if (r < 71) return omrs_pkg::OP_RANK;
        if (r < 82) return omrs_pkg::OP_KTH;
        if (r < 90) return omrs_pkg::OP_PRED;
        if (r < 98) return omrs_pkg::OP_SUCC;
        return 3'($urandom_range(6, 7));
    endfunction

    // receiver: random stall pattern plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else if (random_stall) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    initial begin
        #200ms;
        $display("ordered_multiset_rank_select_top_test: FAIL");
        $finish;
    end

    initial begin
        int k, burst, cnt;
        logic signed [31:0] v;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        hold_off = 1'b0;
        random_stall = 1'b0;
        for (int i = 0; i < 16; i++) pool[i] = $urandom;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-store misses, extremes, duplicates, every opcode
        send_item(omrs_pkg::OP_KTH, 32'sd1);
        send_item(omrs_pkg::OP_PRED, 32'sd0);
        send_item(omrs_pkg::OP_SUCC, 32'sd0);
        send_item(omrs_pkg::OP_DELETE, 32'sd5);
        send_item(omrs_pkg::OP_RANK, 32'sh80000000);
        send_item(omrs_pkg::OP_INSERT, 32'sh7fffffff);
        send_item(omrs_pkg::OP_INSERT, 32'sh80000000);
        send_item(omrs_pkg::OP_INSERT, 32'sd0);
        send_item(omrs_pkg::OP_INSERT, 32'sd0);
        send_item(omrs_pkg::OP_INSERT, -32'sd1);
        send_item(omrs_pkg::OP_RANK, 32'sd0);
        send_item(omrs_pkg::OP_RANK, 32'sh7fffffff);
        send_item(omrs_pkg::OP_KTH, 32'sd0);
        send_item(omrs_pkg::OP_KTH, 32'sd5);
        send_item(omrs_pkg::OP_KTH, 32'sd6);
        send_item(omrs_pkg::OP_KTH, 32'sh80000000);
        send_item(omrs_pkg::OP_PRED, 32'sh80000000);
        send_item(omrs_pkg::OP_SUCC, 32'sh7fffffff);
        send_item(omrs_pkg::OP_PRED, 32'sd0);
        send_item(omrs_pkg::OP_SUCC, 32'sd0);
        send_item(omrs_pkg::OP_DELETE, 32'sd0);
        send_item(omrs_pkg::OP_DELETE, 32'sd7);
        send_item(3'd6, 32'sd1);
        send_item(3'd7, -32'sd1);
        idle_cycles(1);

        // random traffic in bursts, receiver stalling at random
        random_stall = 1'b1;
        k = 0;
        while (k < 900) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k < 900; b++) begin
                // hold-off midway: sender keeps offering while the output blocks
                if (k == 400) fork
                    begin
                        hold_off = 1'b1;
                        cnt = 0;
                        while (cnt < 300) begin
                            @(posedge aclk);
                            cnt++;
                        end
                        hold_off = 1'b0;
                    end
                join_none
                send_item(pick_op(k < 750), pick_value());
                k++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);
        random_stall = 1'b0;

        // fill to capacity with few distinct values, then probe full and drain
        while (sb.vals.size() < omrs_pkg::CAPACITY) begin
            v = pool[$urandom_range(0, 3)];
            send_item(omrs_pkg::OP_INSERT, v);
        end
        send_item(omrs_pkg::OP_INSERT, 32'sd0);
        send_item(omrs_pkg::OP_KTH, 32'(omrs_pkg::CAPACITY));
        send_item(omrs_pkg::OP_KTH, 32'(omrs_pkg::CAPACITY + 1));
        send_item(omrs_pkg::OP_RANK, 32'sh7fffffff);
        idle_cycles(1);

        cnt = 0;
        while (sb.pending.size() != 0 && cnt < 200000) begin
            @(posedge aclk);
            cnt++;
        end
        repeat (50) @(posedge aclk);

        $display("covered %0d items, %0d results checked, peak fill %0d, %0d full inserts",
                 sent, sb.checked, sb.peak, sb.full_hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ordered_multiset_rank_select_top_test: PASS");
        else
            $display("ordered_multiset_rank_select_top_test: FAIL");
        $finish;
    end
endmodule
